FILE: design/lca_pkg.sv
// Package for the lowest-common-ancestor block: sizes, state and select codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package lca_pkg;

    // Node index width; the node count follows from it
    localparam int NODE_W  = 10;
    localparam int NODES   = 1 << NODE_W;
    // Jump levels per node
    localparam int LEVELS  = 10;
    localparam int LEVEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    // Depth field
    localparam int DEPTH_W = 10;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    // Jump table is addressed as {node, level}
    localparam int JMP_DEPTH = NODES << LEVEL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LEVELS - 1);

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_DRD,
        ST_LD_DWR,
        ST_LD_JRD,
        ST_LD_JWR,
        ST_Q_CHK,
        ST_Q_DB,
        ST_Q_SW,
        ST_L1_RD,
        ST_L1_DEP,
        ST_L1_CMP,
        ST_MID,
        ST_L2_RU,
        ST_L2_RV,
        ST_L2_CMP,
        ST_FIN_RD,
        ST_FIN_CAP,
        ST_RES_RD,
        ST_RES_OUT
    } t_state;

    // Jump table read address select
    typedef enum logic [1:0] {
        JRD_U,
        JRD_V,
        JRD_U0,
        JRD_MID
    } t_jrd_sel;

    // Depth table read address select
    typedef enum logic [1:0] {
        DRD_U,
        DRD_V,
        DRD_UP,
        DRD_RES
    } t_drd_sel;

    // Level counter operation
    typedef enum logic [2:0] {
        K_HOLD,
        K_ONE,
        K_TOP,
        K_INC,
        K_DEC
    } t_k_op;

    typedef struct packed {
        logic     ld_in;
        t_jrd_sel jrd_sel;
        t_drd_sel drd_sel;
        logic     dep_wr;
        logic     jmp_wr0;
        logic     jmp_wrk;
        logic     cap_du;
        logic     cap_dv_swap;
        logic     cap_up;
        logic     lift1;
        logic     cap_pu;
        logic     lift2;
        logic     res_u;
        logic     res_jmp;
        logic     out_ld;
        t_k_op    k_op;
    } t_dp_cmd;

    typedef struct packed {
        logic same;
        logic k_zero;
        logic k_last;
    } t_dp_stat;

endpackage

FILE: design/lca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/lca_dp.sv
// Datapath: jump and depth tables, working node registers, level counter
// and result registers. Uses lca_pkg and lca_ram.
module lca_dp
    import lca_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [NODE_W-1:0]   i_node_a,
    input  logic [NODE_W-1:0]   i_node_b,
    output t_dp_stat            o_stat,
    output logic [NODE_W-1:0]   o_ancestor_node,
    output logic [DEPTH_W-1:0]  o_ancestor_depth
);

    localparam int JA_W = NODE_W + LEVEL_W;

    logic [NODE_W-1:0]  r_u, r_v, r_mid, r_up, r_pu, r_res;
    logic [DEPTH_W-1:0] r_du, r_dv;
    logic [LEVEL_W-1:0] r_k;
    logic [NODE_W-1:0]  r_out_node;
    logic [DEPTH_W-1:0] r_out_depth;

    logic [LEVEL_W-1:0] w_k_prev;
    logic [JA_W-1:0]    w_jraddr, w_jwaddr;
    logic [NODE_W-1:0]  w_jwdata, w_jrd;
    logic [NODE_W-1:0]  w_draddr;
    logic [DEPTH_W-1:0] w_dwdata, w_drd;

    assign w_k_prev = r_k - LEVEL_W'(1);

    // Jump table read address
    always_comb begin
        case (i_cmd.jrd_sel)
            JRD_U:   w_jraddr = {r_u, r_k};
            JRD_V:   w_jraddr = {r_v, r_k};
            JRD_U0:  w_jraddr = {r_u, LEVEL_W'(0)};
            JRD_MID: w_jraddr = {r_mid, w_k_prev};
            default: w_jraddr = {r_u, r_k};
        endcase
    end

    // Depth table read address
    always_comb begin
        case (i_cmd.drd_sel)
            DRD_U:   w_draddr = r_u;
            DRD_V:   w_draddr = r_v;
            DRD_UP:  w_draddr = w_jrd;
            DRD_RES: w_draddr = r_res;
            default: w_draddr = r_u;
        endcase
    end

    // Jump row writes: level 0 takes the parent, later levels the read data
    assign w_jwaddr = i_cmd.jmp_wr0 ? {r_u, LEVEL_W'(0)} : {r_u, r_k};
    assign w_jwdata = i_cmd.jmp_wr0 ? r_v : w_jrd;

    // Root gets depth 0, child gets parent depth plus one, saturating
    assign w_dwdata = (r_u == r_v)        ? '0 :
                      (w_drd == DEPTH_MAX) ? DEPTH_MAX :
                      w_drd + DEPTH_W'(1);

    lca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (JMP_DEPTH)
    ) u_jmp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.jmp_wr0 | i_cmd.jmp_wrk),
        .i_waddr (w_jwaddr),
        .i_wdata (w_jwdata),
        .i_raddr (w_jraddr),
        .o_rdata (w_jrd)
    );

    lca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODES)
    ) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.dep_wr),
        .i_waddr (r_u),
        .i_wdata (w_dwdata),
        .i_raddr (w_draddr),
        .o_rdata (w_drd)
    );

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_u <= i_node_a;
            r_v <= i_node_b;
        end
        if (i_cmd.jmp_wr0) begin
            r_mid <= r_v;
        end
        if (i_cmd.jmp_wrk) begin
            r_mid <= w_jrd;
        end
        if (i_cmd.cap_du) begin
            r_du <= w_drd;
        end
        // Put the deeper node in u; keep the depth of the shallower one
        if (i_cmd.cap_dv_swap) begin
            if (r_du < w_drd) begin
                r_u  <= r_v;
                r_v  <= r_u;
                r_dv <= r_du;
            end else begin
                r_dv <= w_drd;
            end
        end
        if (i_cmd.cap_up) begin
            r_up <= w_jrd;
        end
        // First pass: climb while not above the other node's depth
        if (i_cmd.lift1 && (w_drd >= r_dv)) begin
            r_u <= r_up;
        end
        if (i_cmd.cap_pu) begin
            r_pu <= w_jrd;
        end
        // Second pass: climb both while their ancestors differ
        if (i_cmd.lift2 && (r_pu != w_jrd)) begin
            r_u <= r_pu;
            r_v <= w_jrd;
        end
        if (i_cmd.res_u) begin
            r_res <= r_u;
        end
        if (i_cmd.res_jmp) begin
            r_res <= w_jrd;
        end
        if (i_cmd.out_ld) begin
            r_out_node  <= r_res;
            r_out_depth <= w_drd;
        end
    end

    // Level counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else begin
            case (i_cmd.k_op)
                K_HOLD:  r_k <= r_k;
                K_ONE:   r_k <= LEVEL_W'(1);
                K_TOP:   r_k <= LEVEL_TOP;
                K_INC:   r_k <= r_k + LEVEL_W'(1);
                K_DEC:   r_k <= w_k_prev;
                default: r_k <= r_k;
            endcase
        end
    end

    assign o_stat.same   = (r_u == r_v);
    assign o_stat.k_zero = (r_k == '0);
    assign o_stat.k_last = (r_k == LEVEL_TOP);

    assign o_ancestor_node  = r_out_node;
    assign o_ancestor_depth = r_out_depth;

endmodule

FILE: design/lca_ctrl.sv
// Controller: sequences table reads and writes for loads and queries.
// Uses lca_pkg; drives lca_dp through t_dp_cmd.
module lca_ctrl
    import lca_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy,
    output logic     o_result_valid
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    // State and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = (i_op == OP_QUERY) ? ST_Q_CHK : ST_LD_DRD;
                end
            end
            // Load: parent depth, then level 0, then levels 1 and up
            ST_LD_DRD: begin
                o_cmd.drd_sel = DRD_V;
                n_state = ST_LD_DWR;
            end
            ST_LD_DWR: begin
                o_cmd.dep_wr  = 1'b1;
                o_cmd.jmp_wr0 = 1'b1;
                o_cmd.k_op    = K_ONE;
                if (LEVELS > 1) begin
                    n_state = ST_LD_JRD;
                end else begin
                    o_cmd.res_u = 1'b1;
                    n_state = ST_RES_RD;
                end
            end
            ST_LD_JRD: begin
                o_cmd.jrd_sel = JRD_MID;
                n_state = ST_LD_JWR;
            end
            ST_LD_JWR: begin
                o_cmd.jmp_wrk = 1'b1;
                if (i_stat.k_last) begin
                    o_cmd.res_u = 1'b1;
                    n_state = ST_RES_RD;
                end else begin
                    o_cmd.k_op = K_INC;
                    n_state = ST_LD_JRD;
                end
            end
            // Query: same node short cut, then both depths
            ST_Q_CHK: begin
                o_cmd.drd_sel = DRD_U;
                if (i_stat.same) begin
                    o_cmd.res_u = 1'b1;
                    n_state = ST_RES_RD;
                end else begin
                    n_state = ST_Q_DB;
                end
            end
            ST_Q_DB: begin
                o_cmd.drd_sel = DRD_V;
                o_cmd.cap_du  = 1'b1;
                n_state = ST_Q_SW;
            end
            ST_Q_SW: begin
                o_cmd.cap_dv_swap = 1'b1;
                o_cmd.k_op = K_TOP;
                n_state = ST_L1_RD;
            end
            // First pass: jump entry, its depth, compare
            ST_L1_RD: begin
                o_cmd.jrd_sel = JRD_U;
                n_state = ST_L1_DEP;
            end
            ST_L1_DEP: begin
                o_cmd.cap_up  = 1'b1;
                o_cmd.drd_sel = DRD_UP;
                n_state = ST_L1_CMP;
            end
            ST_L1_CMP: begin
                o_cmd.lift1 = 1'b1;
                if (i_stat.k_zero) begin
                    n_state = ST_MID;
                end else begin
                    o_cmd.k_op = K_DEC;
                    n_state = ST_L1_RD;
                end
            end
            ST_MID: begin
                if (i_stat.same) begin
                    o_cmd.res_u = 1'b1;
                    n_state = ST_RES_RD;
                end else begin
                    o_cmd.k_op = K_TOP;
                    n_state = ST_L2_RU;
                end
            end
            // Second pass: both jump entries, compare
            ST_L2_RU: begin
                o_cmd.jrd_sel = JRD_U;
                n_state = ST_L2_RV;
            end
            ST_L2_RV: begin
                o_cmd.cap_pu  = 1'b1;
                o_cmd.jrd_sel = JRD_V;
                n_state = ST_L2_CMP;
            end
            ST_L2_CMP: begin
                o_cmd.lift2 = 1'b1;
                if (i_stat.k_zero) begin
                    n_state = ST_FIN_RD;
                end else begin
                    o_cmd.k_op = K_DEC;
                    n_state = ST_L2_RU;
                end
            end
            // Answer is the parent of the final u
            ST_FIN_RD: begin
                o_cmd.jrd_sel = JRD_U0;
                n_state = ST_FIN_CAP;
            end
            ST_FIN_CAP: begin
                o_cmd.res_jmp = 1'b1;
                n_state = ST_RES_RD;
            end
            // Depth of the answer, then present it
            ST_RES_RD: begin
                o_cmd.drd_sel = DRD_RES;
                n_state = ST_RES_OUT;
            end
            ST_RES_OUT: begin
                o_cmd.out_ld = 1'b1;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;

endmodule

FILE: design/tree_lca_binary_lifting_top.sv
// Top level of the lowest-common-ancestor block over a binary-lifting table.
// Uses lca_pkg, lca_ctrl and lca_dp.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   i_op = load: i_node_a is loaded with parent i_node_b (itself for a root);
//     parents must be loaded before their children. The result is the loaded
//     node and its depth.
//   i_op = query: the result is the lowest common ancestor of i_node_a and
//     i_node_b and its depth.
//   Each request gives one result, shown on o_ancestor_node/o_ancestor_depth
//   for one cycle with o_result_valid high; the receiver cannot stall it.
// Sequencing: a load reads the parent depth, writes the depth and level 0,
//   then reads and writes each higher level; a query of equal nodes skips
//   the depth reads and lifting passes. busy falls as the strobe rises, so the
//   next request may be taken in the strobe cycle. Each table has a single read port:
//   every jump level costs one read, and a lifting step also waits on a depth read.
// Reset: the controller returns to idle; table contents are kept and are
//   undefined until loaded. Entries never loaded must not be queried.
module tree_lca_binary_lifting_top
    import lca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    output logic               o_result_valid,
    output logic [NODE_W-1:0]  o_ancestor_node,
    output logic [DEPTH_W-1:0] o_ancestor_depth
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lca_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_op           (i_op),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    lca_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .o_stat           (w_stat),
        .o_ancestor_node  (o_ancestor_node),
        .o_ancestor_depth (o_ancestor_depth)
    );

endmodule

FILE: dv/tree_lca_binary_lifting_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for tree_lca_binary_lifting_top: loads random forests
// parent-first, queries lowest common ancestors and checks every result.
// Depends on lca_pkg and the tree_lca_binary_lifting_top RTL.
module tree_lca_binary_lifting_top_tb;
    import lca_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    typedef logic [NODE_W-1:0] t_node;

    typedef struct packed {
        logic  op;
        t_node node_a;
        t_node node_b;
    } t_lca_req;

    typedef struct packed {
        t_node              node;
        logic [DEPTH_W-1:0] depth;
    } t_lca_ans;

    // DUT signals; the driven inputs are known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_op = OP_LOAD;
    t_node              i_node_a = '0;
    t_node              i_node_b = '0;
    logic               o_result_valid;
    t_node              o_ancestor_node;
    logic [DEPTH_W-1:0] o_ancestor_depth;

    tree_lca_binary_lifting_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .o_result_valid   (o_result_valid),
        .o_ancestor_node  (o_ancestor_node),
        .o_ancestor_depth (o_ancestor_depth)
    );

    always #5 i_clk = ~i_clk;

    // Request stream and expected answers
    t_lca_req pending_reqs[$];
    t_lca_ans expected_answers[$];
    logic     req_taken = 1'b0;
    int       sender_idle_pct = 0;
    int       n_queued = 0;
    int       n_accepted = 0;
    int       n_results = 0;
    int       n_loads = 0;
    int       n_queries = 0;
    int       n_errors = 0;
    int       stall_cycles = 0;
    int       deepest = 0;

    // Predictor copy of the lifting and depth tables
    t_node              lift_tab [NODES*LEVELS];
    logic [DEPTH_W-1:0] depth_tab [NODES];

    // Generator bookkeeping: which nodes have been loaded and with what parent
    bit    node_seen [NODES];
    t_node gen_parent [NODES];
    t_node loaded_list[$];

    function automatic t_node lift_of(input t_node n, input int k);
        return lift_tab[n*LEVELS + k];
    endfunction

    // Apply one request to the predictor tables and return its answer
    function automatic t_lca_ans compute_answer(input logic op, input t_node a,
                                                input t_node b);
        t_lca_ans           ans;
        t_node              u, v, t, pu, pv;
        logic [DEPTH_W-1:0] d;
        int                 k;
        if (op == OP_LOAD) begin
            if (a == b) begin
                depth_tab[a] = '0;
            end else begin
                d = depth_tab[b];
                depth_tab[a] = (d == DEPTH_MAX) ? DEPTH_MAX : d + DEPTH_W'(1);
            end
            lift_tab[a*LEVELS] = b;
            for (k = 1; k < LEVELS; k++)
                lift_tab[a*LEVELS + k] = lift_of(lift_of(a, k - 1), k - 1);
            ans.node = a;
        end else begin
            u = a;
            v = b;
            if (u == v) begin
                ans.node = u;
            end else begin
                if (depth_tab[u] < depth_tab[v]) begin
                    t = u;
                    u = v;
                    v = t;
                end
                // bring u up to v's depth
                for (k = LEVELS - 1; k >= 0; k--) begin
                    pu = lift_of(u, k);
                    if (depth_tab[pu] >= depth_tab[v])
                        u = pu;
                end
                if (u == v) begin
                    ans.node = u;
                end else begin
                    // climb both while ancestors differ
                    for (k = LEVELS - 1; k >= 0; k--) begin
                        pu = lift_of(u, k);
                        pv = lift_of(v, k);
                        if (pu != pv) begin
                            u = pu;
                            v = pv;
                        end
                    end
                    ans.node = lift_of(u, 0);
                end
            end
        end
        ans.depth = depth_tab[ans.node];
        return ans;
    endfunction

    task automatic flag_error(input string msg);
        if (n_errors < 10)
            $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // Driver: presents the next request at the falling edge, idling at random
    always @(negedge i_clk) begin : driver
        t_lca_req req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                req = pending_reqs.pop_front();
                start <= 1'b1;
                i_op <= req.op;
                i_node_a <= req.node_a;
                i_node_b <= req.node_b;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, predicts accepted requests, watches for hangs
    always @(posedge i_clk) begin : monitor
        t_lca_ans want;
        bit       progress;
        progress = 0;
        if (i_rst_n && o_result_valid) begin
            progress = 1;
            n_results++;
            if (expected_answers.size() == 0) begin
                flag_error($sformatf("unexpected result node=%0d depth=%0d",
                                     o_ancestor_node, o_ancestor_depth));
            end else begin
                want = expected_answers.pop_front();
                if (o_ancestor_node !== want.node)
                    flag_error($sformatf("result %0d: ancestor_node exp %0d got %0d",
                                         n_results, want.node, o_ancestor_node));
                if (o_ancestor_depth !== want.depth)
                    flag_error($sformatf("result %0d: ancestor_depth exp %0d got %0d",
                                         n_results, want.depth, o_ancestor_depth));
                if (want.depth > deepest)
                    deepest = want.depth;
            end
        end
        req_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            progress = 1;
            n_accepted++;
            expected_answers.insert(expected_answers.size(),
                                    compute_answer(i_op, i_node_a, i_node_b));
        end
        if (progress) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic queue_request(input logic op, input t_node a, input t_node b);
        t_lca_req req;
        req.op = op;
        req.node_a = a;
        req.node_b = b;
        pending_reqs.insert(pending_reqs.size(), req);
        n_queued++;
        if (op == OP_LOAD) begin
            n_loads++;
            if (!node_seen[a])
                loaded_list.insert(loaded_list.size(), a);
            node_seen[a] = 1'b1;
            gen_parent[a] = b;
        end else begin
            n_queries++;
        end
    endtask

    // Favor recently loaded nodes half the time so trees grow deep
    function automatic t_node pick_loaded();
        int sz, span;
        sz = loaded_list.size();
        span = (sz > 8) ? 7 : sz - 1;
        if ($urandom_range(1))
            return loaded_list[sz - 1 - $urandom_range(span)];
        return loaded_list[$urandom_range(sz - 1)];
    endfunction

    task automatic random_load();
        t_node child, parent;
        int    tries;
        child = t_node'($urandom_range(NODES - 1));
        for (tries = 0; tries < 4 && node_seen[child]; tries++)
            child = t_node'($urandom_range(NODES - 1));
        if (loaded_list.size() == 0 || $urandom_range(99) < 4)
            parent = child;
        else
            parent = pick_loaded();
        queue_request(OP_LOAD, child, parent);
    endtask

    task automatic random_query();
        t_node a, b;
        int    steps, s;
        a = pick_loaded();
        case ($urandom_range(9))
            0: b = a;
            1, 2: begin
                // an ancestor of a, a few parent steps up
                b = a;
                steps = $urandom_range(6);
                for (s = 0; s < steps; s++)
                    b = gen_parent[b];
            end
            default: b = pick_loaded();
        endcase
        if ($urandom_range(1))
            queue_request(OP_QUERY, a, b);
        else
            queue_request(OP_QUERY, b, a);
    endtask

    task automatic random_items(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (loaded_list.size() == 0 || $urandom_range(99) < 45)
                random_load();
            else
                random_query();
        end
    endtask

    // Two nodes reloaded under each other build a long chain of depths
    task automatic long_chain();
        t_node a, b;
        int    n;
        a = t_node'(NODES / 2);
        b = t_node'(NODES / 2 + 1);
        queue_request(OP_LOAD, a, a);
        for (n = 0; n < 150; n++) begin
            if (n % 2 == 0)
                queue_request(OP_LOAD, b, a);
            else
                queue_request(OP_LOAD, a, b);
        end
        queue_request(OP_QUERY, a, b);
        queue_request(OP_QUERY, b, a);
        queue_request(OP_QUERY, a, a);
        for (n = 0; n < 6; n++)
            queue_request(OP_QUERY, (n % 2) ? a : b, pick_loaded());
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || n_accepted != n_queued
               || expected_answers.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 1: light sender idling, directed requests first
        sender_idle_pct = 8;
        queue_request(OP_LOAD, 10'd0, 10'd0);
        queue_request(OP_LOAD, 10'd1, 10'd0);
        queue_request(OP_LOAD, 10'd2, 10'd0);
        queue_request(OP_LOAD, 10'd3, 10'd1);
        queue_request(OP_LOAD, 10'd4, 10'd3);
        queue_request(OP_LOAD, 10'd1023, 10'd4);
        queue_request(OP_LOAD, 10'd5, 10'd2);
        queue_request(OP_LOAD, 10'd1022, 10'd1022);
        queue_request(OP_LOAD, 10'd6, 10'd1022);
        queue_request(OP_QUERY, 10'd3, 10'd4);
        queue_request(OP_QUERY, 10'd4, 10'd5);
        queue_request(OP_QUERY, 10'd0, 10'd4);
        queue_request(OP_QUERY, 10'd4, 10'd0);
        queue_request(OP_QUERY, 10'd1023, 10'd1023);
        queue_request(OP_QUERY, 10'd0, 10'd0);
        queue_request(OP_QUERY, 10'd1023, 10'd5);
        queue_request(OP_QUERY, 10'd6, 10'd4);
        queue_request(OP_QUERY, 10'd1023, 10'd6);
        queue_request(OP_QUERY, 10'd2, 10'd1023);
        queue_request(OP_QUERY, 10'd1023, 10'd1);
        random_items(250);
        wait_idle();

        // Phase 2: heavy sender idling
        sender_idle_pct = 76;
        random_items(250);
        wait_idle();

        // Phase 3: back-to-back requests, then a long chain
        sender_idle_pct = 0;
        random_items(100);
        long_chain();
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_answers.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_answers.size()));
        $display("Ran %0d loads and %0d queries over %0d distinct nodes,",
                 n_loads, n_queries, loaded_list.size());
        $display("deepest answer at depth %0d, %0d results checked, %0d mismatches.",
                 deepest, n_results, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
